### rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // Result status codes.
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Most results that one request can produce (a three-byte UTF-8 sequence).
    localparam int unsigned MAX_RESULTS = 3;

    // Result bundle handed from the decoder to the result buffer.
    typedef struct packed {
        logic [1:0]                     count;
        logic [1:0]                     status;
        logic [MAX_RESULTS-1:0][7:0]    bytes;
    } res_t;

endpackage

`default_nettype wire

### rtl/json_string_unescaper_top.sv
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------
// input    | in_valid / in_ready  | in_byte[7:0], end_marker
// output   | out_valid / out_ready| out_byte[7:0], status[1:0], last
//
// A request is registered on acceptance and decoded, once the buffer can
// take its results, into a small result buffer, which presents one result
// per cycle while out_ready is high. With the output ready, one request a
// cycle is sustained while each request gives at most one result; a \u
// escape of two or three UTF-8 bytes holds the input while the buffer drains.
// Reset (rst_n low, asynchronous) returns the decoder to waiting for an
// opening quote and empties both the input register and the result buffer.
// A stalled output holds the buffer, which in turn holds the input register.

module json_string_unescaper_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_marker,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       status,
    output logic             last
);
    import jsu_pkg::*;

    // Input register: holds one accepted request until it is decoded.
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;

    // Decoder and result buffer handshake.
    logic        can_load;
    logic        advance;
    res_t        res;

    // A held request is decoded once the result buffer can take its
    // results; the input register refills in the same cycle.
    assign advance  = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    // Payload needs no reset; it is only looked at while marked valid.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
            end_reg  <= end_marker;
        end
    end

    // Scanner state and the escape and UTF-8 decoding.
    jsu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_byte    (byte_reg),
        .end_marker (end_reg),
        .res        (res)
    );

    // Result buffer: presents up to three results, the last one flagged.
    jsu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_no_decode_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !advance)
        else $error("request decoded while the buffer still had results");
`endif

endmodule

`default_nettype wire

### rtl/jsu_decode.sv
`default_nettype none

module jsu_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic [7:0]    in_byte,
    input  wire logic          end_marker,
    output jsu_pkg::res_t      res
);
    import jsu_pkg::*;

    typedef enum logic [6:0] {
        MODE_WAIT = 7'b0000001,
        MODE_BODY = 7'b0000010,
        MODE_ESC  = 7'b0000100,
        MODE_HEX1 = 7'b0001000,
        MODE_HEX2 = 7'b0010000,
        MODE_HEX3 = 7'b0100000,
        MODE_HEX4 = 7'b1000000
    } mode_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    mode_t        mode_reg, mode_next;
    logic [15:0]  cp_reg, cp_next;
    logic [4:0]   hex;
    logic [15:0]  cp_shift;

    // Returns {valid, value} for one ASCII hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    assign hex      = hex_value(in_byte);
    assign cp_shift = {cp_reg[11:0], hex[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        cp_next    = cp_reg;
        res.count  = 2'd0;
        res.status = ST_BYTE;
        res.bytes  = '0;

        case (mode_reg)
            MODE_WAIT:
            begin
                if (!end_marker && in_byte == CH_QUOTE) begin
                    mode_next = MODE_BODY;
                    cp_next   = 16'd0;
                end
            end
            MODE_BODY:
            begin
                if (end_marker) begin
                    res.count = 2'd1;
                    res.status = ST_ERROR;
                    mode_next = MODE_WAIT;
                    cp_next = 16'd0;
                end else if (in_byte == CH_QUOTE) begin
                    res.count = 2'd1;
                    res.status = ST_DONE;
                    mode_next = MODE_WAIT;
                    cp_next = 16'd0;
                end else if (in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    res.count = 2'd1;
                    res.bytes[0] = in_byte;
                end
            end
            MODE_ESC:
            begin
                res.count = 2'd1;
                mode_next = MODE_BODY;
                if (end_marker) begin
                    res.status = ST_ERROR;
                    mode_next = MODE_WAIT;
                    cp_next = 16'd0;
                end else begin
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = in_byte;
                        CH_B: res.bytes[0] = 8'h08;
                        CH_F: res.bytes[0] = 8'h0C;
                        CH_N: res.bytes[0] = 8'h0A;
                        CH_R: res.bytes[0] = 8'h0D;
                        CH_T: res.bytes[0] = 8'h09;
                        CH_U:
                        begin
                            res.count = 2'd0;
                            mode_next = MODE_HEX1;
                            cp_next = 16'd0;
                        end
                        default:
                        begin
                            res.status = ST_ERROR;
                            mode_next = MODE_WAIT;
                            cp_next = 16'd0;
                        end
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4:
            begin
                if (end_marker || !hex[4]) begin
                    res.count = 2'd1;
                    res.status = ST_ERROR;
                    mode_next = MODE_WAIT;
                    cp_next = 16'd0;
                end else begin
                    cp_next = cp_shift;
                    case (mode_reg)
                        MODE_HEX1: mode_next = MODE_HEX2;
                        MODE_HEX2: mode_next = MODE_HEX3;
                        MODE_HEX3: mode_next = MODE_HEX4;
                        default:   mode_next = MODE_BODY;
                    endcase
                    if (mode_reg == MODE_HEX4) begin
                        // Encode the gathered code point as UTF-8.
                        if (cp_shift[15:7] == 9'd0) begin
                            res.count = 2'd1;
                            res.bytes[0] = cp_shift[7:0];
                        end else if (cp_shift[15:11] == 5'd0) begin
                            res.count = 2'd2;
                            res.bytes[0] = {3'b110, cp_shift[10:6]};
                            res.bytes[1] = {2'b10, cp_shift[5:0]};
                        end else begin
                            res.count = 2'd3;
                            res.bytes[0] = {4'b1110, cp_shift[15:12]};
                            res.bytes[1] = {2'b10, cp_shift[11:6]};
                            res.bytes[2] = {2'b10, cp_shift[5:0]};
                        end
                    end
                end
            end
            default:
            begin
                mode_next = MODE_WAIT;
                cp_next   = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_WAIT;
            cp_reg   <= 16'd0;
        end else if (advance) begin
            mode_reg <= mode_next;
            cp_reg   <= cp_next;
        end
    end

`ifndef SYNTHESIS
    a_wait_cp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_WAIT) |-> (cp_reg == 16'd0))
        else $error("code point not cleared while waiting");
    a_hex4_to_body: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == MODE_HEX4 && res.status == ST_BYTE)
            |=> (mode_reg == MODE_BODY))
        else $error("fourth hex digit did not return to string body");
`endif

endmodule

`default_nettype wire

### rtl/jsu_emit.sv
`default_nettype none

module jsu_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  jsu_pkg::res_t      res,
    output logic               can_load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic [1:0]         status,
    output logic               last
);
    import jsu_pkg::*;

    logic [1:0]                   count_reg, count_next;
    logic [1:0]                   status_reg, status_next;
    logic [MAX_RESULTS-1:0][7:0]  buf_reg, buf_next;
    logic                         pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign out_byte  = buf_reg[0];
    assign status    = status_reg;
    assign last      = (count_reg == 2'd1);

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        buf_next    = buf_reg;
        if (load) begin
            count_next  = res.count;
            status_next = res.status;
            buf_next    = res.bytes;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
            buf_next   = {8'd0, buf_reg[MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        buf_reg    <= buf_next;
    end

`ifndef SYNTHESIS
    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != ST_BYTE) |-> (count_reg == 2'd1))
        else $error("done or error result is not a single result");
    a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != ST_BYTE) |-> (out_byte == 8'd0))
        else $error("done or error result carries a non-zero byte");
`endif

endmodule

`default_nettype wire

### dv/json_string_unescaper_top_tb.sv
`default_nettype none

// Checks the JSON string unescaper against a behavioural predictor kept in
// this module. Requests are queued up front by the stimulus block, presented
// by a clocked driver with random gaps, and each accepted request is run
// through the predictor, which appends the results it should cause to a
// queue. A clocked monitor compares every accepted result, field by field,
// with the oldest entry of that queue.

module json_string_unescaper_top_tb;

    import jsu_pkg::*;

    // Characters with a special meaning in a JSON string.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Both sides hold back in roughly this many cycles out of a hundred.
    localparam int IDLE_PCT = 34;

    // Window of accepted requests within which neither side idles, so that
    // back-to-back traffic and the multi-byte stall are seen at full rate.
    localparam int CALM_FIRST = 100;
    localparam int CALM_LAST  = 160;

    // Number of string requests the random part aims for.
    localparam int RANDOM_REQUESTS = 180;

    // Where the decoder stands within a string.
    typedef enum logic [2:0] {
        SCAN_WAIT,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX1,
        SCAN_HEX2,
        SCAN_HEX3,
        SCAN_HEX4
    } scan_e;

    // One request on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       ended;
    } text_req_t;

    // One decoded result on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_marker = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    text_req_t  text_q[$];
    decoded_t   decoded_q[$];

    // Predictor state.
    scan_e       scan_mode = SCAN_WAIT;
    logic [15:0] code_point = 16'h0000;

    int  accepted_count = 0;
    int  fail_count = 0;
    int  string_reqs = 0;
    logic calm;

    // The escape letters that stand for a single byte; \u is handled on its own.
    logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

    json_string_unescaper_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .end_marker (end_marker),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset is held low only at the start and released on a rising edge.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    assign calm = (accepted_count >= CALM_FIRST) && (accepted_count < CALM_LAST);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Returns {valid, nibble} for a hex digit in either case.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - "a" + 10)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - "A" + 10)};
        return 5'b0_0000;
    endfunction

    function automatic void push_decoded(input logic [7:0] b, input logic [1:0] st,
                                         input logic lst);
        decoded_t r;
        r.data   = b;
        r.status = st;
        r.last   = lst;
        decoded_q = {decoded_q, r};
    endfunction

    // A malformed string gives one error result and drops back to waiting.
    function automatic void reject_string();
        push_decoded(8'h00, ST_ERROR, 1'b1);
        scan_mode  = SCAN_WAIT;
        code_point = 16'h0000;
    endfunction

    // Encodes the gathered code point as one, two or three UTF-8 bytes.
    function automatic void emit_code_point(input logic [15:0] cp);
        if (cp <= 16'h007F)
        begin
            push_decoded(cp[7:0], ST_BYTE, 1'b1);
        end
        else if (cp <= 16'h07FF)
        begin
            push_decoded(8'hC0 | {3'b000, cp[10:6]}, ST_BYTE, 1'b0);
            push_decoded(8'h80 | {2'b00, cp[5:0]}, ST_BYTE, 1'b1);
        end
        else
        begin
            push_decoded(8'hE0 | {4'b0000, cp[15:12]}, ST_BYTE, 1'b0);
            push_decoded(8'h80 | {2'b00, cp[11:6]}, ST_BYTE, 1'b0);
            push_decoded(8'h80 | {2'b00, cp[5:0]}, ST_BYTE, 1'b1);
        end
    endfunction

    // Advances the predictor by one accepted request.
    function automatic void unescape_step(input logic [7:0] c, input logic ended);
        logic [4:0] hx;
        if (scan_mode == SCAN_WAIT)
        begin
            // Stray bytes and end markers are ignored until a quote opens a string.
            if (!ended && c == CH_QUOTE)
            begin
                scan_mode  = SCAN_BODY;
                code_point = 16'h0000;
            end
        end
        else if (ended)
        begin
            reject_string();
        end
        else if (scan_mode == SCAN_BODY)
        begin
            if (c == CH_QUOTE)
            begin
                push_decoded(8'h00, ST_DONE, 1'b1);
                scan_mode  = SCAN_WAIT;
                code_point = 16'h0000;
            end
            else if (c == CH_BSLASH)
                scan_mode = SCAN_ESC;
            else
                push_decoded(c, ST_BYTE, 1'b1);
        end
        else if (scan_mode == SCAN_ESC)
        begin
            scan_mode = SCAN_BODY;
            case (c)
                CH_QUOTE, CH_BSLASH, "/": push_decoded(c, ST_BYTE, 1'b1);
                "b": push_decoded(8'h08, ST_BYTE, 1'b1);
                "f": push_decoded(8'h0C, ST_BYTE, 1'b1);
                "n": push_decoded(8'h0A, ST_BYTE, 1'b1);
                "r": push_decoded(8'h0D, ST_BYTE, 1'b1);
                "t": push_decoded(8'h09, ST_BYTE, 1'b1);
                "u":
                begin
                    scan_mode  = SCAN_HEX1;
                    code_point = 16'h0000;
                end
                default: reject_string();
            endcase
        end
        else
        begin
            // One of the four hex digits of a \u escape.
            hx = hex_nibble(c);
            if (!hx[4])
            begin
                reject_string();
            end
            else
            begin
                code_point = {code_point[11:0], hx[3:0]};
                if (scan_mode == SCAN_HEX4)
                begin
                    scan_mode = SCAN_BODY;
                    emit_code_point(code_point);
                end
                else
                    scan_mode = scan_e'(scan_mode + 3'd1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_req(input logic [7:0] b, input logic ended);
        text_req_t r;
        r.data  = b;
        r.ended = ended;
        text_q = {text_q, r};
    endtask

    // A hex digit for the given nibble, in upper or lower case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'("0") + 8'(nib);
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
    endfunction

    task automatic add_unicode(input logic [15:0] cp);
        add_req(CH_BSLASH, 1'b0);
        add_req("u", 1'b0);
        add_req(hex_char(cp[15:12]), 1'b0);
        add_req(hex_char(cp[11:8]), 1'b0);
        add_req(hex_char(cp[7:4]), 1'b0);
        add_req(hex_char(cp[3:0]), 1'b0);
    endtask

    function automatic logic is_escape_letter(input logic [7:0] b);
        foreach (esc_letters[i])
            if (esc_letters[i] == b)
                return 1'b1;
        return (b == "u");
    endfunction

    // Queues one random string. Most strings are well formed with random
    // content; a minority break off with an unknown escape, a bad hex digit
    // or an end marker somewhere inside.
    task automatic add_random_string();
        int          n_elems;
        int          kind;
        int          start_len;
        int          n_digits;
        logic [7:0]  b;
        logic [15:0] cp;
        logic        broken;
        start_len = text_q.size();
        broken = 1'b0;
        add_req(CH_QUOTE, 1'b0);
        n_elems = $urandom_range(0, 8);
        for (int k = 0; k < n_elems && !broken; k++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE || b == CH_BSLASH)
                    b = b ^ 8'h01;
                add_req(b, 1'b0);
            end
            else if (kind < 65)
            begin
                add_req(CH_BSLASH, 1'b0);
                add_req(esc_letters[$urandom_range(0, 7)], 1'b0);
            end
            else if (kind < 92)
            begin
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                add_unicode(cp);
            end
            else
            begin
                broken = 1'b1;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        add_req(CH_BSLASH, 1'b0);
                        do
                            b = 8'($urandom_range(0, 255));
                        while (is_escape_letter(b));
                        add_req(b, 1'b0);
                    end
                    1:
                    begin
                        add_req(CH_BSLASH, 1'b0);
                        add_req("u", 1'b0);
                        n_digits = $urandom_range(0, 3);
                        repeat (n_digits)
                            add_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
                        do
                            b = 8'($urandom_range(0, 255));
                        while (hex_nibble(b) != 5'b0_0000);
                        add_req(b, 1'b0);
                    end
                    default:
                    begin
                        // End of input inside the body, after a backslash or
                        // part way through a \u escape.
                        case ($urandom_range(0, 2))
                            1: add_req(CH_BSLASH, 1'b0);
                            2:
                            begin
                                add_req(CH_BSLASH, 1'b0);
                                add_req("u", 1'b0);
                                n_digits = $urandom_range(0, 3);
                                repeat (n_digits)
                                    add_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
                            end
                            default: ;
                        endcase
                        add_req(8'($urandom_range(0, 255)), 1'b1);
                    end
                endcase
            end
        end
        if (!broken)
            add_req(CH_QUOTE, 1'b0);
        string_reqs += text_q.size() - start_len;
    endtask

    // ------------------------------------------------------------------
    // Stimulus, end of run
    // ------------------------------------------------------------------

    initial
    begin
        int waited;
        logic [7:0] b;

        // Directed part. Ignored traffic before any string is open: an end
        // marker and a stray byte.
        add_req(8'hA5, 1'b1);
        add_req("a", 1'b0);
        // Open a string, pass the top byte through, expand a simple escape,
        // the largest and the zero code point, then cut the input short.
        add_req(CH_QUOTE, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(CH_BSLASH, 1'b0);
        add_req("n", 1'b0);
        add_req(CH_BSLASH, 1'b0);
        add_req("u", 1'b0);
        add_req("F", 1'b0);
        add_req("f", 1'b0);
        add_req("f", 1'b0);
        add_req("F", 1'b0);
        add_unicode(16'h0000);
        add_req(8'h5A, 1'b1);
        // An unknown escape letter.
        add_req(CH_QUOTE, 1'b0);
        add_req(CH_BSLASH, 1'b0);
        add_req("q", 1'b0);
        // A non-hex digit inside a \u escape.
        add_req(CH_QUOTE, 1'b0);
        add_req(CH_BSLASH, 1'b0);
        add_req("u", 1'b0);
        add_req("1", 1'b0);
        add_req("g", 1'b0);
        // The empty string, closed straight away.
        add_req(CH_QUOTE, 1'b0);
        add_req(CH_QUOTE, 1'b0);

        // Random part, with a little noise between strings that the block
        // should simply ignore.
        while (string_reqs < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE);
                    add_req(b, 1'($urandom_range(0, 1)));
                end
            end
            add_random_string();
        end

        // Wait for the driver to empty its queue and for the last request
        // to be taken.
        while (text_q.size() != 0 || in_valid)
            @(posedge clk);

        // Then for every outstanding result, within a bound.
        waited = 0;
        while (decoded_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end

        // Then a last wait, so that any stray result still in the pipeline
        // is caught by the monitor.
        repeat (20) @(posedge clk);

        if (decoded_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // This bound leaves a wide margin over the slowest correct run.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    // A new request is presented only once the previous one has been taken
    // (or none was pending); while valid is high the payload is held.
    // Each signal gets at most one assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_byte    <= 8'h00;
            end_marker <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid   <= 1'b1;
                in_byte    <= text_q[0].data;
                end_marker <= text_q[0].ended;
                text_q.delete(0);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiving side stalls at random, except in the calm window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------

    // Both channels are sampled at the rising edge, before this edge's
    // updates land. Each accepted request runs through the predictor first;
    // since a result only appears once its request has passed the input
    // register and the result buffer, the order in this block never matters.
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                unescape_step(in_byte, end_marker);
                accepted_count <= accepted_count + 1;
            end

            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result byte=%02h status=%0d last=%0b",
                             $time, out_byte, status, last);
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data || status !== want.status
                        || last !== want.last)
                    begin
                        $display("%0t: mismatch expected byte=%02h status=%0d last=%0b,",
                                 $time, want.data, want.status, want.last,
                                 " actual byte=%02h status=%0d last=%0b",
                                 out_byte, status, last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire
